// File: rtl/assert_macros.svh
// assertion helpers shared by the fifo and back end rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CLCD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define CLCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/clcd_pkg.sv
package clcd_pkg;

  // expander byte control bits
  localparam int BIT_BL = 3;
  localparam int BIT_EN = 2;
  localparam int BIT_RW = 1;
  localparam int BIT_RS = 0;

  // character codes
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_RETURN   = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // set ddram address command
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  // zero-based row index, up to four rows
  localparam int ROW_W = 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  typedef struct packed {
    logic       has_data;
    logic       has_cmd;
    logic [7:0] data_byte;
    logic [7:0] cmd_byte;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] row_base(input logic [ROW_W-1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      2'd3:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

endpackage

// File: rtl/clcd_front.sv
module clcd_front #(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        character,
  output logic              job_valid,
  output clcd_pkg::job_t    job
);
  import clcd_pkg::*;

  localparam int COL_W = $clog2(COLUMNS);

  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic             is_print;
  logic             is_newline;
  logic             is_return;
  logic             col_wrap;

  always_comb begin
    is_print   = character inside {[CH_PRINT_LO:CH_PRINT_HI]};
    is_newline = (character == CH_NEWLINE);
    is_return  = (character == CH_RETURN);
    col_wrap   = (column == COL_W'(COLUMNS - 1));
  end

  always_comb begin
    column_next = column;
    row_next    = row;
    if (accept) begin
      if (is_print) begin
        column_next = col_wrap ? '0 : column + COL_W'(1);
      end else if (is_newline) begin
        column_next = '0;
        row_next    = (row == ROW_W'(ROWS - 1)) ? '0 : row + ROW_W'(1);
      end else if (is_return) begin
        column_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else begin
      column <= column_next;
      row    <= row_next;
    end
  end

  // every jump lands on column one, so the address is just the row base
  always_comb begin
    job_valid     = accept && (is_print || is_newline || is_return);
    job.has_data  = is_print;
    job.has_cmd   = !is_print || col_wrap;
    job.data_byte = character;
    job.cmd_byte  = CMD_SET_ADDR | row_base(row_next);
  end

endmodule

// File: rtl/clcd_fifo.sv
module clcd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  clcd_pkg::job_t      wr_data,
  input  logic                rd_en,
  output clcd_pkg::job_t      rd_data,
  output clcd_pkg::q_status_t status
);
  import clcd_pkg::*;
  `include "assert_macros.svh"

  job_t               mem [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + Q_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_comb begin
    rd_data      = mem[rd_ptr];
    status.full  = (count == Q_CNT_W'(QUEUE_DEPTH));
    status.empty = (count == '0);
  end

  `CLCD_ASSERT(a_no_overflow, clk, rst, !(wr_en && status.full), "queue write while full")
  `CLCD_ASSERT(a_no_underflow, clk, rst, !(rd_en && status.empty), "queue read while empty")
  `CLCD_ASSERT(a_count_range, clk, rst, count <= Q_CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// File: rtl/clcd_back.sv
module clcd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                backlight_on,
  input  clcd_pkg::q_status_t q_status,
  input  clcd_pkg::job_t      q_data,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          expander_byte,
  output logic                last_of_run
);
  import clcd_pkg::*;
  `include "assert_macros.svh"

  job_t       cur;
  logic       busy;
  logic [2:0] step;
  logic       out_valid;
  logic       advance;
  logic       is_last;
  logic [7:0] lcd_byte;
  logic [3:0] nibble;
  logic [7:0] gen_byte;

  // step[2]: command byte (the second lcd byte when there is data), step[1]: low nibble, step[0]: enable dropped
  always_comb begin
    advance  = busy && (!out_valid || pop);
    is_last  = (step == 3'd7) || (step == 3'd3 && !cur.has_cmd);
    q_rd     = !q_status.empty && (!busy || (advance && is_last));
    lcd_byte = step[2] ? cur.cmd_byte : cur.data_byte;
    nibble   = step[1] ? lcd_byte[3:0] : lcd_byte[7:4];
    gen_byte = {nibble, 4'b0000};
    gen_byte[BIT_BL] = backlight_on;
    gen_byte[BIT_EN] = !step[0];
    gen_byte[BIT_RW] = 1'b0;
    gen_byte[BIT_RS] = !step[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (q_rd) begin
      busy <= 1'b1;
      step <= q_data.has_data ? 3'd0 : 3'd4;
    end else if (advance && is_last) begin
      busy <= 1'b0;
    end else if (advance) begin
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      expander_byte <= gen_byte;
      last_of_run   <= is_last;
    end
  end

  assign empty = !out_valid;

  `CLCD_ASSERT(a_cmd_only_start, clk, rst, (busy && !cur.has_data) |-> step[2], "command-only job in data half")
  `CLCD_ASSERT(a_run_restart, clk, rst, (advance && is_last) |=> (!busy || step == 3'd0 || step == 3'd4), "new run not at its first step")
  `CLCD_ASSERT(a_job_has_work, clk, rst, busy |-> (cur.has_data || cur.has_cmd), "job with nothing to send")

endmodule

// File: rtl/char_lcd_i2c_nibble_writer.sv
// channel   direction  handshake              payload
// input     in         push / full            character
// result    out        pop / empty            expander_byte, last_of_run
// config    in         cfg_valid / cfg_ready  cfg_data (backlight_on)
//
// a character is taken whenever the queue has room
// each character yields 0, 4 or 8 expander bytes, one per cycle while the result is popped
// sustained rate is set by the back end byte sequencer
// a stalled result holds the back end; the front keeps taking requests until the queue fills
// reset clears the cursor to row 1, column 1, sets backlight on and empties all stages
module char_lcd_i2c_nibble_writer #(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] character,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] expander_byte,
  output logic       last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import clcd_pkg::*;

  logic      backlight_on;
  logic      accept;
  logic      job_valid;
  job_t      job;
  job_t      q_data;
  logic      q_rd;
  q_status_t q_status;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      backlight_on <= cfg_data;
    end
  end

  // request accepted whenever the job queue has room
  assign full   = q_status.full;
  assign accept = push && !full;

  // front: classify the character and move the cursor
  clcd_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .character (character),
    .job_valid (job_valid),
    .job       (job)
  );

  // short queue of pending jobs, dropped characters never enter it
  clcd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_valid),
    .wr_data (job),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .status  (q_status)
  );

  // back: split each lcd byte into four expander bytes behind an output register
  clcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .backlight_on  (backlight_on),
    .q_status      (q_status),
    .q_data        (q_data),
    .q_rd          (q_rd),
    .pop           (pop),
    .empty         (empty),
    .expander_byte (expander_byte),
    .last_of_run   (last_of_run)
  );

endmodule

// File: tb/char_lcd_i2c_nibble_writer_tb.sv
module char_lcd_i2c_nibble_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clcd_pkg::*;

  localparam int COLUMNS        = 20;
  localparam int ROWS           = 4;
  localparam int MAX_GAP        = 18;
  localparam int HOLD_OFF       = 300;   // long receiver stall for the fill-up test
  localparam int QUIET_CYCLES   = 32;    // back end time to finish after the last expected byte, queue of 2
  localparam int WATCHDOG_LIMIT = 3000;  // cycles in a row with no request moving

  // ddram base address of rows 1..4, row 1 in the low byte
  localparam logic [31:0] ROW_OFFSETS = {8'h54, 8'h14, 8'h40, 8'h00};

  typedef struct packed {
    logic [7:0] xbyte;
    logic       last;
  } lcd_write_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] character = 8'h00;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] expander_byte;
  logic       last_of_run;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // predicted expander bytes still to come, oldest first
  lcd_write_t writes_due[$];

  // cursor and backlight as the block should hold them
  int   col_now = 1;
  int   row_now = 1;
  logic backlight_now = 1'b1;

  int mismatches = 0;
  int stall_cycles = 0;
  bit reset_done = 1'b0;
  bit in_burst = 1'b0;    // sender offers back to back
  bit out_burst = 1'b0;   // receiver pops back to back
  int hold_request = 0;   // one-shot long stall for the receiver

  char_lcd_i2c_nibble_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .character    (character),
    .pop          (pop),
    .empty        (empty),
    .expander_byte(expander_byte),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one lcd byte in 4-bit mode: high nibble strobed, then low nibble strobed
  function automatic void queue_lcd_byte(logic [7:0] value, logic is_data, logic ends_run);
    logic [7:0] ctl;
    logic [7:0] en;
    logic [7:0] hi;
    logic [7:0] lo;
    ctl = 8'h00;
    ctl[BIT_BL] = backlight_now;
    ctl[BIT_RS] = is_data;
    en = 8'h00;
    en[BIT_EN] = 1'b1;
    hi = {value[7:4], 4'h0} | ctl;
    lo = {value[3:0], 4'h0} | ctl;
    writes_due.push_back(lcd_write_t'{hi | en, 1'b0});
    writes_due.push_back(lcd_write_t'{hi, 1'b0});
    writes_due.push_back(lcd_write_t'{lo | en, 1'b0});
    writes_due.push_back(lcd_write_t'{lo, ends_run});
  endfunction

  // set-address command for the current cursor, always the end of a run
  function automatic void queue_cursor_move();
    logic [7:0] addr;
    addr = CMD_SET_ADDR | ROW_OFFSETS[8*(row_now-1) +: 8];
    addr = 8'(addr + col_now - 1);
    queue_lcd_byte(addr, 1'b0, 1'b1);
  endfunction

  function automatic void predict_character(logic [7:0] ch);
    if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
      col_now++;
      // the data byte ends the run unless the column wraps
      queue_lcd_byte(ch, 1'b1, col_now <= COLUMNS);
      if (col_now > COLUMNS) begin
        col_now = 1;
        queue_cursor_move();
      end
    end else if (ch == CH_NEWLINE) begin
      col_now = 1;
      row_now = (row_now == ROWS) ? 1 : row_now + 1;
      queue_cursor_move();
    end else if (ch == CH_RETURN) begin
      col_now = 1;
      queue_cursor_move();
    end
    // anything else is dropped with no bytes and no cursor change
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // mostly text with line breaks, some arbitrary codes
  function automatic logic [7:0] random_character();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    if (pick < 80) return CH_NEWLINE;
    if (pick < 88) return CH_RETURN;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one character and wait for its request to be taken; push stays high
  // into the next call when that call draws no gap
  task automatic send_character(logic [7:0] ch);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    character <= ch;
    do @(posedge clk); while (full);
    predict_character(ch);
  endtask

  // stop offering, let every expected byte out, then give the back end time
  // to finish; characters that make no bytes never enter the queue
  task automatic wait_drained();
    push <= 1'b0;
    while (writes_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_backlight(logic value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    backlight_now = value;
  endtask

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  initial begin
    int gap;
    wait (reset_done);
    forever begin
      // a requested hold-off replaces the usual random wait once
      if (hold_request > 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = draw_gap(out_burst);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // compare every popped byte with the oldest prediction
  always @(posedge clk) begin
    lcd_write_t want;
    if (!rst && pop && !empty) begin
      if (writes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected expander byte %02h last_of_run %0b", expander_byte, last_of_run);
      end else begin
        want = writes_due.pop_front();
        if (expander_byte !== want.xbyte) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expander_byte: expected %02h, got %02h", want.xbyte, expander_byte);
        end
        if (last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("last_of_run after byte %02h: expected %0b, got %0b",
                     want.xbyte, want.last, last_of_run);
        end
      end
    end
  end

  // watchdog: any request moving on any channel resets the count
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // printable bounds, codes just outside them, top and bottom codes,
  // return, and four newlines so the row wraps back to the first
  task automatic test_directed_codes();
    logic [7:0] codes[$];
    codes = '{8'h20, 8'h7E, 8'h1F, 8'h7F, 8'h00, 8'hFF, 8'h80, 8'h41, CH_NEWLINE,
              8'h42, CH_RETURN, CH_NEWLINE, CH_NEWLINE, CH_NEWLINE, 8'h0B, 8'h0C,
              8'h09, 8'h5A};
    in_burst = 1'b0;
    out_burst = 1'b0;
    foreach (codes[i]) send_character(codes[i]);
    wait_drained();
  endtask

  // a full line and then some, so the column passes the end and wraps
  task automatic test_column_wrap();
    in_burst = 1'b1;
    out_burst = 1'b1;
    send_character(CH_RETURN);
    repeat (COLUMNS + 2) send_character(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
    in_burst = 1'b0;
    out_burst = 1'b0;
    wait_drained();
  endtask

  // backlight off on data and commands, then back on
  task automatic test_backlight();
    write_backlight(1'b0);
    send_character(8'h61);
    send_character(CH_NEWLINE);
    send_character(8'h7E);
    send_character(CH_RETURN);
    write_backlight(1'b1);
    send_character(8'h20);
    wait_drained();
  endtask

  // receiver stalls long while the sender keeps offering, so the block fills
  // and holds full until the receiver comes back
  task automatic test_backpressure();
    wait_drained();
    in_burst = 1'b1;
    hold_request = HOLD_OFF;
    repeat (40) send_character(random_character());
    in_burst = 1'b0;
    wait_drained();
  endtask

  // random text in phases, each with its own backlight and idling pattern
  task automatic test_random_text(int count);
    int phase_len;
    phase_len = 50;
    for (int sent = 0; sent < count; sent += phase_len) begin
      write_backlight(1'($urandom_range(0, 1)));
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      repeat (phase_len) send_character(random_character());
    end
    in_burst = 1'b0;
    out_burst = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;

    test_directed_codes();
    test_column_wrap();
    test_backlight();
    test_backpressure();
    test_random_text(150);

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/clcd_pkg.sv
rtl/clcd_front.sv
rtl/clcd_fifo.sv
rtl/clcd_back.sv
rtl/char_lcd_i2c_nibble_writer.sv
tb/char_lcd_i2c_nibble_writer_tb.sv
